/* rtl/tbdc_pkg.sv */
// Shared constants, state codes and the edge transition table for the
// two-beam direction counter. No dependencies.
package tbdc_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // detector states
  localparam logic [STATE_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STATE_W-1:0] ST_S1    = 4'd1;
  localparam logic [STATE_W-1:0] ST_S2    = 4'd2;
  localparam logic [STATE_W-1:0] ST_S3    = 4'd3;
  localparam logic [STATE_W-1:0] ST_S4    = 4'd4;
  localparam logic [STATE_W-1:0] ST_S5    = 4'd5;
  localparam logic [STATE_W-1:0] ST_S6    = 4'd6;
  localparam logic [STATE_W-1:0] ST_S7    = 4'd7;
  localparam logic [STATE_W-1:0] ST_S8    = 4'd8;
  localparam logic [STATE_W-1:0] ST_ERROR = 4'd9;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_EDGE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_TIMEOUT = 2'd1;

  localparam logic [CNT_W-1:0] BASE_TIMEOUT_RST  = 16'd5000;
  localparam logic [CNT_W-1:0] ERROR_TIMEOUT_RST = 16'd10000;

  localparam logic BEAM_FIRST  = 1'b0;
  localparam logic LEVEL_FALL  = 1'b0;

  // next state after a beam edge; unchanged when no move applies
  function automatic logic [STATE_W-1:0] edge_next(input logic [STATE_W-1:0] s,
                                                    input logic beam,
                                                    input logic level);
    logic [STATE_W-1:0] n;
    n = s;
    if (beam == BEAM_FIRST) begin
      if (level == LEVEL_FALL) begin
        case (s)
          ST_IDLE: n = ST_S1;
          ST_S2:   n = ST_S1;
          ST_S4:   n = ST_S3;
          ST_S5:   n = ST_S7;
          ST_S6:   n = ST_S8;
          default: n = s;
        endcase
      end else begin
        case (s)
          ST_S1:   n = ST_S2;
          ST_S3:   n = ST_S4;
          ST_S7:   n = ST_S5;
          ST_S8:   n = ST_IDLE;
          default: n = s;
        endcase
      end
    end else begin
      if (level != LEVEL_FALL) begin
        case (s)
          ST_S3:   n = ST_S1;
          ST_S4:   n = ST_IDLE;
          ST_S5:   n = ST_S6;
          ST_S7:   n = ST_S8;
          default: n = s;
        endcase
      end else begin
        case (s)
          ST_S1:   n = ST_S3;
          ST_S2:   n = ST_S4;
          ST_IDLE: n = ST_S5;
          ST_S6:   n = ST_S5;
          ST_S8:   n = ST_S7;
          default: n = s;
        endcase
      end
    end
    return n;
  endfunction

endpackage

/* rtl/two_beam_direction_counter_top.sv */
// Two-beam direction counter, top level.
// Depends on tbdc_pkg (state codes, request kinds, edge transition table).
//
// Usage:
//   in_*  : request items. in_tuser carries the request kind (edge, tick,
//           load); in_tdata carries beam select, beam level and load value.
//   out_* : one result item per request: detector state, entry/exit counts,
//           occupant total and the entry/exit flags of that request.
//   cfg_* : register writes (base and error timeout in ticks), always ready.
//           Index 2 and 3 are ignored.
// The result is registered: the item is captured in the input register, and
// the state update then loads the result register. Throughput is one item per
// cycle while out_tready does not stall, set by the state update loop.
// A stalled out_tready holds the result; one more item waits in the input
// register, after which in_tready drops.
// Reset (rst_n low, synchronous) sets the idle state, clears elapsed time
// and all counts, loads default timeouts 5000 and 10000, and empties both
// registers.
module two_beam_direction_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // beam_select[0], beam_level[1], load_value[17:2], zero pad
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // detect_state[3:0], entry_count[19:4], exit_count[35:20],
                                  // occupant_total[51:36], entry_seen[52], exit_seen[53], pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned W  = tbdc_pkg::CNT_W;
  localparam int unsigned SW = tbdc_pkg::STATE_W;

  // input register
  logic                        s1_valid_r;
  logic [tbdc_pkg::REQ_W-1:0]  s1_req_r;
  logic                        s1_beam_r;
  logic                        s1_level_r;
  logic [W-1:0]                s1_load_r;

  // block state
  logic [SW-1:0] state_r, state_nxt;
  logic [W-1:0]  elapsed_r, elapsed_nxt;
  logic [W-1:0]  entries_r, entries_nxt;
  logic [W-1:0]  exits_r, exits_nxt;
  logic [W-1:0]  occ_r, occ_nxt;
  logic [W-1:0]  base_to_r, error_to_r;

  // result register
  logic          out_valid_r;
  logic          entry_seen_r, entry_nxt;
  logic          exit_seen_r, exit_nxt;

  logic out_free, s1_fire;
  logic [SW-1:0] edge_n;
  logic [W-1:0]  elapsed_inc, limit;
  logic          base_kind;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_req_r   <= in_tuser;
      s1_beam_r  <= in_tdata[0];
      s1_level_r <= in_tdata[1];
      s1_load_r  <= in_tdata[17:2];
    end
  end

  always_comb begin
    edge_n      = tbdc_pkg::edge_next(state_r, s1_beam_r, s1_level_r);
    base_kind   = state_r inside {tbdc_pkg::ST_S2, tbdc_pkg::ST_S6};
    limit       = base_kind ? base_to_r : error_to_r;
    elapsed_inc = (elapsed_r == tbdc_pkg::CNT_MAX) ? elapsed_r : elapsed_r + 1'b1;

    state_nxt   = state_r;
    elapsed_nxt = elapsed_r;
    entries_nxt = entries_r;
    exits_nxt   = exits_r;
    occ_nxt     = occ_r;
    entry_nxt   = 1'b0;
    exit_nxt    = 1'b0;

    case (s1_req_r)
      tbdc_pkg::REQ_EDGE: begin
        if (state_r != tbdc_pkg::ST_ERROR && edge_n != state_r) begin
          state_nxt   = edge_n;
          elapsed_nxt = '0;
          entry_nxt   = (state_r == tbdc_pkg::ST_S4) && (edge_n == tbdc_pkg::ST_IDLE);
          exit_nxt    = (state_r == tbdc_pkg::ST_S8) && (edge_n == tbdc_pkg::ST_IDLE);
        end
      end
      tbdc_pkg::REQ_TICK: begin
        if (state_r inside {[tbdc_pkg::ST_S1 : tbdc_pkg::ST_S8]}) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc > limit) begin
            state_nxt   = base_kind ? tbdc_pkg::ST_IDLE : tbdc_pkg::ST_ERROR;
            elapsed_nxt = '0;
          end
        end
      end
      tbdc_pkg::REQ_LOAD: begin
        occ_nxt     = s1_load_r;
        entries_nxt = '0;
        exits_nxt   = '0;
      end
      default: ;
    endcase

    if (entry_nxt) begin
      entries_nxt = (entries_r == tbdc_pkg::CNT_MAX) ? entries_r : entries_r + 1'b1;
      occ_nxt     = (occ_r == tbdc_pkg::CNT_MAX) ? occ_r : occ_r + 1'b1;
    end
    if (exit_nxt) begin
      exits_nxt = (exits_r == tbdc_pkg::CNT_MAX) ? exits_r : exits_r + 1'b1;
      occ_nxt   = (occ_r == '0) ? occ_r : occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbdc_pkg::ST_IDLE;
      elapsed_r   <= '0;
      entries_r   <= '0;
      exits_r     <= '0;
      occ_r       <= '0;
      base_to_r   <= tbdc_pkg::BASE_TIMEOUT_RST;
      error_to_r  <= tbdc_pkg::ERROR_TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tbdc_pkg::CFG_BASE_TIMEOUT) base_to_r <= cfg_data;
        if (cfg_index == tbdc_pkg::CFG_ERROR_TIMEOUT) error_to_r <= cfg_data;
      end
      if (out_free) out_valid_r <= s1_valid_r;
      if (s1_fire) begin
        state_r   <= state_nxt;
        elapsed_r <= elapsed_nxt;
        entries_r <= entries_nxt;
        exits_r   <= exits_nxt;
        occ_r     <= occ_nxt;
      end
    end
    if (s1_fire) begin
      entry_seen_r <= entry_nxt;
      exit_seen_r  <= exit_nxt;
    end
  end

  // state/count registers double as the result payload
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, exit_seen_r, entry_seen_r, occ_r, exits_r, entries_r, state_r};

  // assertions
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(entry_seen_r && exit_seen_r))
    else $error("entry and exit flagged by one item");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbdc_pkg::ST_ERROR) |=> (state_r == tbdc_pkg::ST_ERROR))
    else $error("error state left without reset");

  a_flag_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (entry_seen_r || exit_seen_r)) |-> (state_r == tbdc_pkg::ST_IDLE))
    else $error("completed walk not back in idle");

  a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(state_r) && $stable(occ_r))
    else $error("state changed without an item");

endmodule
